### rtl/im2col_ag_pkg.sv
// Shared types, register codes and size constants of the im2col address generator.
package im2col_ag_pkg;

  // Defaults for the top-level size parameters
  localparam int TILE_ROW_MAX_DEF = 2;
  localparam int DIM_MAX_DEF      = 1024;
  localparam int KERNEL_MAX_DEF   = 15;

  // Fixed field widths
  localparam int REG_W      = 11;
  localparam int REG_IDX_W  = 3;
  localparam int ADDR_W     = 30;
  localparam int ROW_W      = 10;
  localparam int ROWCNT_W   = 2;
  localparam int KREG_W     = 4;
  localparam int PAIR_W     = 8;
  localparam int NIB_W      = 4;
  localparam int STRIDE_MAX = 15;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_PAIR   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PAD_PAIR      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd7;

  // Request payload
  typedef struct packed {
    logic [ROW_W-1:0]    tile_first_row;
    logic [ROWCNT_W-1:0] tile_row_count;
  } in_t;

  // Result payload
  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic              is_padding;
    logic [ADDR_W-1:0] dest_address;
    logic              last_in_patch;
    logic              last_in_tile;
  } out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [REG_W-1:0]  channel_count;
    logic [REG_W-1:0]  in_height;
    logic [REG_W-1:0]  in_width;
    logic [KREG_W-1:0] kernel_height;
    logic [KREG_W-1:0] kernel_width;
    logic [PAIR_W-1:0] stride_pair;
    logic [PAIR_W-1:0] pad_pair;
    logic [REG_W-1:0]  out_width;
  } cfg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEOM,
    ST_ADDR,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;
    logic geom;
    logic addr;
    logic retire;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

### rtl/im2col_patch_address_generator_core.sv
// Top level of the im2col patch address generator.
//
//   Channel   Direction  Handshake             Payload
//   in        request    in_valid / in_ready   in_data  (tile_first_row, tile_row_count)
//   out       result     out_valid / out_ready out_data (addresses, padding and last marks)
//   cfg       write      cfg_write             cfg_index, cfg_data
//
// Each request goes through capture, tap geometry with the channel plane multiply,
// the row scaling multiply, and the final add into the result register.
// The two dependent multiplications of the address path lie in separate steps.
// The result register lets a new request be taken while a result waits; a
// request finished while the previous result is still unclaimed waits in its last step.
// Reset is synchronous and active high; it clears the tile state and restores the
// register defaults.
module im2col_patch_address_generator_core #(
  parameter int TILE_ROW_MAX = im2col_ag_pkg::TILE_ROW_MAX_DEF,
  parameter int DIM_MAX      = im2col_ag_pkg::DIM_MAX_DEF,
  parameter int KERNEL_MAX   = im2col_ag_pkg::KERNEL_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  im2col_ag_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output im2col_ag_pkg::out_t                 out_data,
  input  logic                                cfg_write,
  input  logic [im2col_ag_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [im2col_ag_pkg::REG_W-1:0]     cfg_data
);
  import im2col_ag_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Configuration registers
  im2col_ag_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Controller
  im2col_ag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  im2col_ag_dp #(
    .TILE_ROW_MAX (TILE_ROW_MAX),
    .DIM_MAX      (DIM_MAX),
    .KERNEL_MAX   (KERNEL_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/im2col_ag_regs.sv
// Configuration register file of the im2col address generator.
module im2col_ag_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [im2col_ag_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [im2col_ag_pkg::REG_W-1:0]     cfg_data,
  output im2col_ag_pkg::cfg_t                 cfg
);
  import im2col_ag_pkg::*;

  // Register writes; each register keeps the low bits of the write data
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= REG_W'(1);
      cfg.in_height     <= REG_W'(1);
      cfg.in_width      <= REG_W'(1);
      cfg.kernel_height <= KREG_W'(1);
      cfg.kernel_width  <= KREG_W'(1);
      cfg.stride_pair   <= PAIR_W'(17);
      cfg.pad_pair      <= '0;
      cfg.out_width     <= REG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data;
        REG_IN_HEIGHT:     cfg.in_height     <= cfg_data;
        REG_IN_WIDTH:      cfg.in_width      <= cfg_data;
        REG_KERNEL_HEIGHT: cfg.kernel_height <= cfg_data[KREG_W-1:0];
        REG_KERNEL_WIDTH:  cfg.kernel_width  <= cfg_data[KREG_W-1:0];
        REG_STRIDE_PAIR:   cfg.stride_pair   <= cfg_data[PAIR_W-1:0];
        REG_PAD_PAIR:      cfg.pad_pair      <= cfg_data[PAIR_W-1:0];
        REG_OUT_WIDTH:     cfg.out_width     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/im2col_ag_ctrl.sv
// Sequencing state machine of the im2col address generator.
module im2col_ag_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  im2col_ag_pkg::stat_t stat,
  output im2col_ag_pkg::cmd_t  cmd
);
  import im2col_ag_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: take a request, work out its geometry and address, then retire it
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_GEOM;
      ST_GEOM: state_next = ST_ADDR;
      ST_ADDR: state_next = ST_DONE;
      ST_DONE: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs decoded from the state
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_GEOM: cmd.geom = 1'b1;
      ST_ADDR: cmd.addr = 1'b1;
      ST_DONE: cmd.retire = stat.out_free;
      default: ;
    endcase
  end

  // Only one request is in flight at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule

### rtl/im2col_ag_dp.sv
// Counters, address arithmetic and result register of the im2col address generator.
module im2col_ag_dp #(
  parameter int TILE_ROW_MAX = im2col_ag_pkg::TILE_ROW_MAX_DEF,
  parameter int DIM_MAX      = im2col_ag_pkg::DIM_MAX_DEF,
  parameter int KERNEL_MAX   = im2col_ag_pkg::KERNEL_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  im2col_ag_pkg::cfg_t  cfg,
  input  im2col_ag_pkg::in_t   in_data,
  input  im2col_ag_pkg::cmd_t  cmd,
  output im2col_ag_pkg::stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output im2col_ag_pkg::out_t  out_data
);
  import im2col_ag_pkg::*;

  localparam int CW  = $clog2(DIM_MAX);
  localparam int NW  = CW + 1;
  localparam int KCW = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
  localparam int KNW = $clog2(KERNEL_MAX + 1);
  localparam int RW  = (TILE_ROW_MAX > 1) ? $clog2(TILE_ROW_MAX) : 1;
  localparam int PW  = ((CW > ROW_W) ? CW : ROW_W) + 7;
  localparam int CNW = CW + NW;
  localparam int MW  = CNW + NW;

  // A zero count acts as one, an oversized one as the maximum.
  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned mx);
    int unsigned r;
    r = v;
    if (v == 0) r = 1;
    else if (v > mx) r = mx;
    return r;
  endfunction

  // Tile state and nested counters
  logic                tile_active;
  logic [ROW_W-1:0]    tile_base_row;
  logic [ROWCNT_W-1:0] row_total;
  logic [RW-1:0]       row_offset;
  logic [CW-1:0]       column_counter;
  logic [CW-1:0]       channel_counter;
  logic [KCW-1:0]      kernel_row_counter;
  logic [KCW-1:0]      kernel_col_counter;
  logic [ADDR_W-1:0]   dest_counter;

  // Intermediate registers of the address path
  logic [NW-1:0]     h_idx;
  logic [NW-1:0]     w_idx;
  logic              pad_reg;
  logic [CNW-1:0]    cn_reg;
  logic [ADDR_W-1:0] prod_reg;

  // Effective sizes
  logic [NW-1:0]    nc, nh, nw, ow;
  logic [KNW-1:0]   kh, kw;
  logic [NIB_W-1:0] sh, sw, ph, pw;
  logic [ROWCNT_W-1:0] rows_start;

  always_comb begin
    nc = NW'(clamp_count(32'(cfg.channel_count), DIM_MAX));
    nh = NW'(clamp_count(32'(cfg.in_height), DIM_MAX));
    nw = NW'(clamp_count(32'(cfg.in_width), DIM_MAX));
    ow = NW'(clamp_count(32'(cfg.out_width), DIM_MAX));
    kh = KNW'(clamp_count(32'(cfg.kernel_height), KERNEL_MAX));
    kw = KNW'(clamp_count(32'(cfg.kernel_width), KERNEL_MAX));
    sh = NIB_W'(clamp_count(32'(cfg.stride_pair[PAIR_W-1:NIB_W]), STRIDE_MAX));
    sw = NIB_W'(clamp_count(32'(cfg.stride_pair[NIB_W-1:0]), STRIDE_MAX));
    ph = cfg.pad_pair[PAIR_W-1:NIB_W];
    pw = cfg.pad_pair[NIB_W-1:0];
    rows_start = ROWCNT_W'(clamp_count(32'(in_data.tile_row_count), TILE_ROW_MAX));
  end

  // Tap position in the image, signed so that padding shows as out of range
  logic [ROW_W:0]        row_abs;
  logic signed [PW-1:0]  h_c, w_c;
  logic                  pad_c;

  always_comb begin
    row_abs = (ROW_W+1)'(tile_base_row) + (ROW_W+1)'(row_offset);
    h_c = $signed(PW'(row_abs) * PW'(sh)) + $signed(PW'(kernel_row_counter))
        - $signed(PW'(ph));
    w_c = $signed(PW'(column_counter) * PW'(sw)) + $signed(PW'(kernel_col_counter))
        - $signed(PW'(pw));
    pad_c = (h_c < 0) || (w_c < 0) || (h_c >= $signed(PW'(nh)))
         || (w_c >= $signed(PW'(nw)));
  end

  // Ends of each counter's range; a counter past a new bound counts as at its end
  logic end_kw, end_kh, end_c, end_col, end_row, end_patch, end_tile;

  always_comb begin
    end_kw    = int'(kernel_col_counter) + 1 >= int'(kw);
    end_kh    = int'(kernel_row_counter) + 1 >= int'(kh);
    end_c     = int'(channel_counter) + 1 >= int'(nc);
    end_col   = int'(column_counter) + 1 >= int'(ow);
    end_row   = int'(row_offset) + 1 >= int'(row_total);
    end_patch = end_kw && end_kh && end_c;
    end_tile  = end_patch && end_col && end_row;
  end

  // Address path: geometry and channel plane offset, then row scaling
  always_ff @(posedge clk) begin
    if (cmd.geom) begin
      h_idx   <= h_c[NW-1:0];
      w_idx   <= w_c[NW-1:0];
      pad_reg <= pad_c;
      cn_reg  <= CNW'(channel_counter) * CNW'(nh);
    end
    if (cmd.addr) begin
      prod_reg <= ADDR_W'(MW'(cn_reg + CNW'(h_idx)) * MW'(nw));
    end
  end

  // Tile start and counter advance
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_active        <= 1'b0;
      tile_base_row      <= '0;
      row_total          <= '0;
      row_offset         <= '0;
      column_counter     <= '0;
      channel_counter    <= '0;
      kernel_row_counter <= '0;
      kernel_col_counter <= '0;
      dest_counter       <= '0;
    end else if (cmd.start && !tile_active) begin
      tile_active        <= 1'b1;
      tile_base_row      <= in_data.tile_first_row;
      row_total          <= rows_start;
      row_offset         <= '0;
      column_counter     <= '0;
      channel_counter    <= '0;
      kernel_row_counter <= '0;
      kernel_col_counter <= '0;
      dest_counter       <= '0;
    end else if (cmd.retire) begin
      dest_counter <= dest_counter + ADDR_W'(1);
      if (!end_kw) begin
        kernel_col_counter <= kernel_col_counter + KCW'(1);
      end else begin
        kernel_col_counter <= '0;
        if (!end_kh) begin
          kernel_row_counter <= kernel_row_counter + KCW'(1);
        end else begin
          kernel_row_counter <= '0;
          if (!end_c) begin
            channel_counter <= channel_counter + CW'(1);
          end else begin
            channel_counter <= '0;
            if (!end_col) begin
              column_counter <= column_counter + CW'(1);
            end else begin
              column_counter <= '0;
              if (!end_row) begin
                row_offset <= row_offset + RW'(1);
              end else begin
                row_offset   <= '0;
                dest_counter <= '0;
                tile_active  <= 1'b0;
              end
            end
          end
        end
      end
    end
  end

  // Result register: holds one result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.retire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.retire) begin
      out_data.source_address <= pad_reg ? '0 : prod_reg + ADDR_W'(w_idx);
      out_data.is_padding     <= pad_reg;
      out_data.dest_address   <= dest_counter;
      out_data.last_in_patch  <= end_patch;
      out_data.last_in_tile   <= end_tile;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  // A padding tap never carries an image address.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.is_padding || out_data.source_address == '0))
    else $error("padding result with a non-zero source address");

  // The end of a tile is always the end of a patch.
  a_tile_ends_patch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_in_tile |-> out_data.last_in_patch)
    else $error("tile ended in the middle of a patch");

  // Retiring the last tap closes the tile.
  a_tile_close: assert property (@(posedge clk) disable iff (rst)
    cmd.retire && end_tile |=> !tile_active)
    else $error("tile still active after its last tap");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !cmd.retire)
    else $error("result overwritten before it was taken");

endmodule

### test/im2col_tap_checker.sv
// Checker that predicts the im2col tap stream of the address generator and compares it.
`timescale 1ns / 100ps

module im2col_tap_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  im2col_ag_pkg::in_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  im2col_ag_pkg::out_t                 out_data,
  input  logic                                cfg_write,
  input  logic [im2col_ag_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [im2col_ag_pkg::REG_W-1:0]     cfg_data,
  output int                                  mismatch_count,
  output int                                  pending_count
);
  import im2col_ag_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the register file and of the tile walk
  cfg_t              regs;
  bit                tile_active;
  logic [ROW_W-1:0]  base_row;
  int                row_total;
  int                row_off;
  int                col_ctr;
  int                chan_ctr;
  int                krow_ctr;
  int                kcol_ctr;
  logic [ADDR_W-1:0] dest_ctr;

  // Taps still owed by the block, oldest first
  out_t expected_taps[$];

  // A size of zero counts as one and anything above the limit as the limit.
  function automatic int effective_size(int v, int lim);
    if (v == 0) begin
      return 1;
    end
    return (v > lim) ? lim : v;
  endfunction

  // Works out the tap for one request and steps the nested counters.
  task automatic next_tap(input in_t req, output out_t tap);
    int     nc, nh, nw, kh, kw, ow, sh, sw;
    longint ph, pw, h_pos, w_pos, flat;
    bit     pad, end_kw, end_kh, end_c, end_col, end_row;
    nc = effective_size(int'(regs.channel_count), DIM_MAX_DEF);
    nh = effective_size(int'(regs.in_height), DIM_MAX_DEF);
    nw = effective_size(int'(regs.in_width), DIM_MAX_DEF);
    kh = effective_size(int'(regs.kernel_height), KERNEL_MAX_DEF);
    kw = effective_size(int'(regs.kernel_width), KERNEL_MAX_DEF);
    ow = effective_size(int'(regs.out_width), DIM_MAX_DEF);
    sh = effective_size(int'(regs.stride_pair[PAIR_W-1:NIB_W]), STRIDE_MAX);
    sw = effective_size(int'(regs.stride_pair[NIB_W-1:0]), STRIDE_MAX);
    ph = longint'(regs.pad_pair[PAIR_W-1:NIB_W]);
    pw = longint'(regs.pad_pair[NIB_W-1:0]);

    // Only a request that opens a tile carries its first row and row count.
    if (!tile_active) begin
      base_row    = req.tile_first_row;
      row_total   = effective_size(int'(req.tile_row_count), TILE_ROW_MAX_DEF);
      row_off     = 0;
      col_ctr     = 0;
      chan_ctr    = 0;
      krow_ctr    = 0;
      kcol_ctr    = 0;
      dest_ctr    = '0;
      tile_active = 1'b1;
    end

    // Position of the tap in the image; outside it the element is padding.
    h_pos = (longint'(base_row) + row_off) * sh + krow_ctr - ph;
    w_pos = longint'(col_ctr) * sw + kcol_ctr - pw;
    pad   = (h_pos < 0) || (h_pos >= nh) || (w_pos < 0) || (w_pos >= nw);
    flat  = pad ? 0 : (longint'(chan_ctr) * nh + h_pos) * nw + w_pos;

    // A counter at or past its bound is on its last value.
    end_kw  = (kcol_ctr + 1) >= kw;
    end_kh  = (krow_ctr + 1) >= kh;
    end_c   = (chan_ctr + 1) >= nc;
    end_col = (col_ctr + 1) >= ow;
    end_row = (row_off + 1) >= row_total;

    tap.source_address = flat[ADDR_W-1:0];
    tap.is_padding     = pad;
    tap.dest_address   = dest_ctr;
    tap.last_in_patch  = end_kw && end_kh && end_c;
    tap.last_in_tile   = end_kw && end_kh && end_c && end_col && end_row;

    // Step the counters, innermost first.
    dest_ctr = dest_ctr + 1'b1;
    if (!end_kw) begin
      kcol_ctr++;
    end else begin
      kcol_ctr = 0;
      if (!end_kh) begin
        krow_ctr++;
      end else begin
        krow_ctr = 0;
        if (!end_c) begin
          chan_ctr++;
        end else begin
          chan_ctr = 0;
          if (!end_col) begin
            col_ctr++;
          end else begin
            col_ctr = 0;
            if (!end_row) begin
              row_off++;
            end else begin
              row_off     = 0;
              dest_ctr    = '0;
              tile_active = 1'b0;
            end
          end
        end
      end
    end
  endtask

  // Counts a failure and reports the first few of them.
  task automatic flag_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s", what);
    end
  endtask

  // Register writes first, then the result check, then the new request.
  always @(posedge clk) begin : watch_channels
    out_t tap;
    out_t want;
    if (rst) begin
      regs.channel_count = 1;
      regs.in_height     = 1;
      regs.in_width      = 1;
      regs.kernel_height = 1;
      regs.kernel_width  = 1;
      regs.stride_pair   = 8'h11;
      regs.pad_pair      = '0;
      regs.out_width     = 1;
      tile_active        = 1'b0;
      base_row           = '0;
      row_total          = 0;
      row_off            = 0;
      col_ctr            = 0;
      chan_ctr           = 0;
      krow_ctr           = 0;
      kcol_ctr           = 0;
      dest_ctr           = '0;
      mismatch_count     = 0;
      expected_taps.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: regs.channel_count = cfg_data;
          REG_IN_HEIGHT:     regs.in_height     = cfg_data;
          REG_IN_WIDTH:      regs.in_width      = cfg_data;
          REG_KERNEL_HEIGHT: regs.kernel_height = cfg_data[KREG_W-1:0];
          REG_KERNEL_WIDTH:  regs.kernel_width  = cfg_data[KREG_W-1:0];
          REG_STRIDE_PAIR:   regs.stride_pair   = cfg_data[PAIR_W-1:0];
          REG_PAD_PAIR:      regs.pad_pair      = cfg_data[PAIR_W-1:0];
          REG_OUT_WIDTH:     regs.out_width     = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_taps.size() == 0) begin
          flag_failure($sformatf("unexpected tap: src=%0d pad=%0b dst=%0d patch=%0b tile=%0b",
                                 out_data.source_address, out_data.is_padding,
                                 out_data.dest_address, out_data.last_in_patch,
                                 out_data.last_in_tile));
        end else begin
          want = expected_taps.pop_front();
          if (out_data !== want) begin
            flag_failure($sformatf({"tap mismatch: expected src=%0d pad=%0b dst=%0d ",
                                    "patch=%0b tile=%0b, got src=%0d pad=%0b dst=%0d ",
                                    "patch=%0b tile=%0b"},
                                   want.source_address, want.is_padding,
                                   want.dest_address, want.last_in_patch,
                                   want.last_in_tile, out_data.source_address,
                                   out_data.is_padding, out_data.dest_address,
                                   out_data.last_in_patch, out_data.last_in_tile));
          end
        end
      end

      if (in_valid && in_ready) begin
        next_tap(in_data, tap);
        expected_taps.push_back(tap);
      end
    end
    pending_count = expected_taps.size();
  end

endmodule

### test/im2col_patch_address_generator_core_tb.sv
// Testbench top: drives requests, configuration and back-pressure, and gives the verdict.
`timescale 1ns / 100ps

module im2col_patch_address_generator_core_tb;
  import im2col_ag_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 5;
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_REQUESTS  = 40;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PRESSURE_CYCLES = 200;
  localparam int PRESSURE_PHASE  = 2;
  localparam int WATCHDOG_LIMIT  = 3000;

  // Kinds of geometry a phase runs with
  typedef enum logic [1:0] {
    SHAPE_TINY,
    SHAPE_SMALL,
    SHAPE_ZERO,
    SHAPE_HUGE
  } shape_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  int mismatch_count;
  int pending_count;
  int quiet_cycles;
  int stall_left;
  int ready_pct;
  bit no_idle;
  bit hold_req;
  bit hold_seen;

  always #(CLK_PERIOD / 2) clk = ~clk;

  im2col_patch_address_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  im2col_tap_checker tap_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Result side: random stalls, the odd long one, and one long hold-off on demand.
  // A flip of hold_req asks for the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        stall_left = PRESSURE_CYCLES;
        hold_seen  = hold_req;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left = $urandom_range(8, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Ends the run when nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cfg_t make_settings(int chans, int height, int width, int k_rows,
                                         int k_cols, int stride, int pad, int out_cols);
    cfg_t s;
    s.channel_count = REG_W'(chans);
    s.in_height     = REG_W'(height);
    s.in_width      = REG_W'(width);
    s.kernel_height = KREG_W'(k_rows);
    s.kernel_width  = KREG_W'(k_cols);
    s.stride_pair   = PAIR_W'(stride);
    s.pad_pair      = PAIR_W'(pad);
    s.out_width     = REG_W'(out_cols);
    return s;
  endfunction

  function automatic in_t make_request(int first_row, int row_count);
    in_t r;
    r.tile_first_row = ROW_W'(first_row);
    r.tile_row_count = ROWCNT_W'(row_count);
    return r;
  endfunction

  function automatic in_t random_request();
    return make_request($urandom_range(0, 1023), $urandom_range(0, 3));
  endfunction

  // Mostly back-to-back, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Writes every register in turn, keeping the write enable high throughout.
  task automatic apply_settings(input cfg_t s);
    logic [REG_W-1:0] value [8];
    value[REG_CHANNEL_COUNT] = s.channel_count;
    value[REG_IN_HEIGHT]     = s.in_height;
    value[REG_IN_WIDTH]      = s.in_width;
    value[REG_KERNEL_HEIGHT] = REG_W'(s.kernel_height);
    value[REG_KERNEL_WIDTH]  = REG_W'(s.kernel_width);
    value[REG_STRIDE_PAIR]   = REG_W'(s.stride_pair);
    value[REG_PAD_PAIR]      = REG_W'(s.pad_pair);
    value[REG_OUT_WIDTH]     = s.out_width;
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= value[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Offers one request, holds it until taken, then idles for the given gap.
  task automatic send_request(input in_t r, input int gap);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering requests and waits until every tap has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    cfg_t   s;
    shape_t shape;
    int     pick;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    ready_pct    = 100;
    no_idle      = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: one tap per row; a zero row count acts as one, three as two.
    send_request(make_request(0, 1), 0);
    send_request(make_request(1023, 2), 0);
    send_request(make_request(0, 3), 0);
    send_request(make_request(5, 0), 0);
    send_request(make_request(0, 3), 0);
    send_request(make_request(1023, 0), 0);

    // Zero stride with padding on both sides of a small image.
    wait_idle();
    apply_settings(make_settings(1, 2, 2, 2, 2, 8'h00, 8'h11, 1));
    send_request(make_request(0, 1), 0);
    repeat (3) send_request(random_request(), 0);

    // Every register at zero.
    wait_idle();
    apply_settings(make_settings(0, 0, 0, 0, 0, 8'h00, 8'h00, 0));
    send_request(make_request(1023, 1), 0);
    send_request(make_request(0, 2), 0);

    // Oversized registers; the tile is left open for the next settings.
    wait_idle();
    apply_settings(make_settings(2047, 2047, 2047, 15, 15, 8'hFF, 8'hFF, 2047));
    send_request(make_request(1023, 3), 0);
    repeat (3) send_request(random_request(), 0);

    // Largest legal sizes, changed under the open tile.
    wait_idle();
    apply_settings(make_settings(1024, 1024, 1024, 15, 15, 8'h11, 8'h00, 1024));
    repeat (4) send_request(random_request(), 0);

    // Random phases, each with its own geometry and idling pattern.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(0, 9);
      if (phase == 1 || (phase != PRESSURE_PHASE && pick == 0)) begin
        shape = SHAPE_HUGE;
      end else if (phase == 5 || (phase != PRESSURE_PHASE && pick == 1)) begin
        shape = SHAPE_ZERO;
      end else if (phase != PRESSURE_PHASE && pick < 5) begin
        shape = SHAPE_TINY;
      end else begin
        shape = SHAPE_SMALL;
      end

      case (shape)
        SHAPE_HUGE: begin
          s = make_settings($urandom_range(1000, 2047), $urandom_range(1000, 2047),
                            $urandom_range(1000, 2047), $urandom_range(13, 15),
                            $urandom_range(13, 15), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(1000, 2047));
        end
        SHAPE_ZERO: begin
          s = make_settings(0, 0, 0, 0, 0, 0, 0, 0);
        end
        SHAPE_TINY: begin
          s = make_settings($urandom_range(0, 1), $urandom_range(1, 4),
                            $urandom_range(1, 4), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 255),
                            ($urandom_range(0, 3) << NIB_W) | $urandom_range(0, 3),
                            $urandom_range(0, 1));
        end
        default: begin
          s = make_settings($urandom_range(1, 3), $urandom_range(1, 8),
                            $urandom_range(1, 8), $urandom_range(1, 3),
                            $urandom_range(1, 3),
                            ($urandom_range(0, 3) << NIB_W) | $urandom_range(0, 3),
                            ($urandom_range(0, 3) << NIB_W) | $urandom_range(0, 3),
                            $urandom_range(1, 3));
        end
      endcase

      wait_idle();
      apply_settings(s);

      // One phase holds the result side off while requests keep coming.
      no_idle   = (phase == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      ready_pct = no_idle ? 100 : $urandom_range(40, 95);
      if (phase == PRESSURE_PHASE) begin
        hold_req = ~hold_req;
      end

      repeat (PHASE_REQUESTS) send_request(random_request(), pick_gap());
    end

    wait_idle();
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### im2col_patch_address_generator_core.f
rtl/im2col_ag_pkg.sv
rtl/im2col_ag_regs.sv
rtl/im2col_ag_ctrl.sv
rtl/im2col_ag_dp.sv
rtl/im2col_patch_address_generator_core.sv
test/im2col_tap_checker.sv
test/im2col_patch_address_generator_core_tb.sv
